// ===== hdl/weekday_alarm_scheduler_unit_defines.svh =====
// assertion macros for the weekday alarm scheduler
`ifndef WEEKDAY_ALARM_SCHEDULER_UNIT_DEFINES_SVH
`define WEEKDAY_ALARM_SCHEDULER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define WASU_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("weekday alarm scheduler: assertion failed");
// property checked on every clock edge, reset included
`define WASU_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("weekday alarm scheduler: assertion failed");
`else
`define WASU_ASSERT(name, clk, rst_n, prop)
`define WASU_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ===== hdl/wasu_pkg.sv =====
package wasu_pkg;

    localparam int MINUTE_W   = 11;
    localparam int DAY_W      = 3;
    localparam int NUM_DAYS   = 7;
    localparam int RING_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [MINUTE_W-1:0] FIRST_MINUTE_RST  = 11'd390;
    localparam logic [NUM_DAYS-1:0] FIRST_DAYS_RST    = 7'b0111110;
    localparam logic [MINUTE_W-1:0] SECOND_MINUTE_RST = 11'd480;
    localparam logic [NUM_DAYS-1:0] SECOND_DAYS_RST   = 7'b1000001;
    localparam logic [RING_W-1:0]   RING_MINUTES_RST  = 8'd30;

    typedef enum logic {
        MODE_TICK      = 1'b0,
        MODE_RECOMPUTE = 1'b1
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALL_ALARMS_ON = 3'd0,
        REG_FIRST_ON      = 3'd1,
        REG_FIRST_MINUTE  = 3'd2,
        REG_FIRST_DAYS    = 3'd3,
        REG_SECOND_ON     = 3'd4,
        REG_SECOND_MINUTE = 3'd5,
        REG_SECOND_DAYS   = 3'd6,
        REG_RING_MINUTES  = 3'd7
    } t_reg_index;

    typedef struct packed {
        logic                mode;
        logic [MINUTE_W-1:0] now_minute;
        logic [DAY_W-1:0]    now_weekday;
    } t_in_item;

    typedef struct packed {
        logic                radio_start;
        logic                radio_stop;
        logic                tripped;
        logic                next_found;
        logic [DAY_W-1:0]    next_day;
        logic [MINUTE_W-1:0] next_minute;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg_item;

endpackage

// ===== hdl/wasu_chan_if.sv =====
interface wasu_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/weekday_alarm_scheduler_unit.sv =====
// Two-alarm weekday alarm unit. Each input item is either a minute tick or a request to
// recompute the next alarm, and each gives exactly one result item. An accepted item is
// held in an input register, processed combinationally (auto-off countdown, alarm trip
// and a seven-day priority pick of the next alarm) and placed in a result register once
// the result side is free, so a new item is taken every cycle while the result side
// keeps up; a stalled result holds one item in each register.
// Configuration writes are always taken and are meant for times when no item is in flight.
module weekday_alarm_scheduler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wasu_chan_if.sink   i_item,
    wasu_chan_if.source o_result,
    wasu_chan_if.sink   i_cfg
);
    import wasu_pkg::*;

`include "weekday_alarm_scheduler_unit_defines.svh"

    // configuration
    logic                r_all_alarms_on;
    logic                r_first_on;
    logic [MINUTE_W-1:0] r_first_minute;
    logic [NUM_DAYS-1:0] r_first_days;
    logic                r_second_on;
    logic [MINUTE_W-1:0] r_second_minute;
    logic [NUM_DAYS-1:0] r_second_days;
    logic [RING_W-1:0]   r_ring_minutes;

    // alarm state
    logic [RING_W-1:0]   r_off_countdown, n_off_countdown;
    logic                r_ringing, n_ringing;
    logic                r_pending_valid, n_pending_valid;
    logic [DAY_W-1:0]    r_pending_day, n_pending_day;
    logic [MINUTE_W-1:0] r_pending_minute, n_pending_minute;

    // pipeline
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out, n_out;
    logic      r_out_valid;
    logic      advance;

    // recompute result
    logic [DAY_W-1:0]    wd;
    logic [NUM_DAYS-1:0] m1, m2;
    logic                l1, l2;
    logic                c1, c2;
    logic [DAY_W:0]      day_sum;
    logic [DAY_W-1:0]    day_k;
    logic [DAY_W-1:0]    pick_day;
    logic                rc_valid;
    logic [DAY_W-1:0]    rc_day;
    logic [MINUTE_W-1:0] rc_minute;
    logic                start, stop;
    logic [RING_W-1:0]   cnt_dec;

    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready   = !r_in_valid || advance;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;
    assign i_cfg.ready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_all_alarms_on <= 1'b0;
            r_first_on      <= 1'b0;
            r_first_minute  <= FIRST_MINUTE_RST;
            r_first_days    <= FIRST_DAYS_RST;
            r_second_on     <= 1'b0;
            r_second_minute <= SECOND_MINUTE_RST;
            r_second_days   <= SECOND_DAYS_RST;
            r_ring_minutes  <= RING_MINUTES_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                REG_ALL_ALARMS_ON: r_all_alarms_on <= i_cfg.data.value[0];
                REG_FIRST_ON:      r_first_on      <= i_cfg.data.value[0];
                REG_FIRST_MINUTE:  r_first_minute  <= i_cfg.data.value[MINUTE_W-1:0];
                REG_FIRST_DAYS:    r_first_days    <= i_cfg.data.value[NUM_DAYS-1:0];
                REG_SECOND_ON:     r_second_on     <= i_cfg.data.value[0];
                REG_SECOND_MINUTE: r_second_minute <= i_cfg.data.value[MINUTE_W-1:0];
                REG_SECOND_DAYS:   r_second_days   <= i_cfg.data.value[NUM_DAYS-1:0];
                REG_RING_MINUTES:  r_ring_minutes  <= i_cfg.data.value[RING_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // seven-day priority pick of the next alarm
    always_comb begin
        wd = (r_in.now_weekday == DAY_W'(NUM_DAYS)) ? '0 : r_in.now_weekday;
        m1 = r_first_on ? r_first_days : '0;
        m2 = r_second_on ? r_second_days : '0;
        l1 = m1[wd] && (r_first_minute > r_in.now_minute);
        l2 = m2[wd] && (r_second_minute > r_in.now_minute);
        rc_valid = 1'b0;
        pick_day = wd;
        c1       = 1'b0;
        c2       = 1'b0;
        day_sum  = '0;
        day_k    = '0;
        // last day in order is today at any minute; lowest offset wins
        for (int k = NUM_DAYS; k >= 1; k--) begin
            day_sum = {1'b0, wd} + (DAY_W+1)'(k);
            if (day_sum >= (DAY_W+1)'(NUM_DAYS)) begin
                day_sum = day_sum - (DAY_W+1)'(NUM_DAYS);
            end
            day_k = day_sum[DAY_W-1:0];
            if (m1[day_k] || m2[day_k]) begin
                rc_valid = 1'b1;
                pick_day = day_k;
                c1       = m1[day_k];
                c2       = m2[day_k];
            end
        end
        if (l1 || l2) begin
            rc_valid = 1'b1;
            pick_day = wd;
            c1       = l1;
            c2       = l2;
        end
        if (c1 && c2) begin
            rc_minute = (r_second_minute < r_first_minute) ? r_second_minute : r_first_minute;
        end else if (c1) begin
            rc_minute = r_first_minute;
        end else if (c2) begin
            rc_minute = r_second_minute;
        end else begin
            rc_minute = '0;
        end
        rc_day = rc_valid ? pick_day : '0;
    end

    always_comb begin
        n_off_countdown  = r_off_countdown;
        n_ringing        = r_ringing;
        n_pending_valid  = r_pending_valid;
        n_pending_day    = r_pending_day;
        n_pending_minute = r_pending_minute;
        start            = 1'b0;
        stop             = 1'b0;
        cnt_dec          = r_off_countdown - RING_W'(1);
        if (r_in.mode == MODE_RECOMPUTE) begin
            n_pending_valid  = rc_valid;
            n_pending_day    = rc_day;
            n_pending_minute = rc_minute;
        end else begin
            if (r_off_countdown != '0) begin
                n_off_countdown = cnt_dec;
                if (cnt_dec == '0) begin
                    stop = 1'b1;
                    if (r_ringing) begin
                        n_ringing        = 1'b0;
                        n_pending_valid  = rc_valid;
                        n_pending_day    = rc_day;
                        n_pending_minute = rc_minute;
                    end
                end
            end
            if (r_all_alarms_on && n_pending_valid && (n_pending_day == wd)
                    && (n_pending_minute == r_in.now_minute)) begin
                n_ringing       = 1'b1;
                n_off_countdown = r_ring_minutes;
                start           = 1'b1;
            end
        end
        n_out.radio_start = start;
        n_out.radio_stop  = stop;
        n_out.tripped     = n_ringing;
        n_out.next_found  = n_pending_valid;
        n_out.next_day    = n_pending_valid ? n_pending_day : '0;
        n_out.next_minute = n_pending_valid ? n_pending_minute : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_off_countdown  <= '0;
            r_ringing        <= 1'b0;
            r_pending_valid  <= 1'b0;
            r_pending_day    <= '0;
            r_pending_minute <= '0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid      <= 1'b1;
                r_off_countdown  <= n_off_countdown;
                r_ringing        <= n_ringing;
                r_pending_valid  <= n_pending_valid;
                r_pending_day    <= n_pending_day;
                r_pending_minute <= n_pending_minute;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in <= i_item.data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    `WASU_ASSERT(a_trip_loads_ring, i_clk, i_rst_n, advance && start |=> r_off_countdown == $past(r_ring_minutes))
    `WASU_ASSERT(a_last_tick_stops, i_clk, i_rst_n, advance && (r_in.mode == MODE_TICK) && (r_off_countdown == RING_W'(1)) |=> r_out_valid && r_out.radio_stop)
    `WASU_ASSERT(a_held_item_kept, i_clk, i_rst_n, r_in_valid && !advance |=> r_in_valid && $stable(r_in))
    `WASU_ASSERT_ALWAYS(a_no_next_zero, i_clk, r_out_valid && !r_out.next_found |-> (r_out.next_day == '0) && (r_out.next_minute == '0))

endmodule
